>>> hw/rtl/assert_macros.svh
// Assertion macros used by the list engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PLE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

   // Defaults for the top-level parameters.
   localparam int CAPACITY_DEF   = 32;
   localparam int DATA_WIDTH_DEF = 32;

   // Cell index width: covers the largest supported capacity (64 cells).
   localparam int CELL_IDX_W = 6;

   // Fixed field widths.
   localparam int OPCODE_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 6;

   // Operation codes of an input item.
   typedef enum logic [OPCODE_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_READ_ALL  = 3'd6
   } op_type;

   // Status codes of a result item.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_BAD_POS = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EMPTY   = 2'd3
   } status_type;

   // What every cell of the chain does on a command.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_kind_type;

   // Command broadcast along the chain.
   typedef struct packed {
      cell_kind_type         kind;
      logic [CELL_IDX_W-1:0] idx;   // Target cell of an insert or delete.
      logic [CELL_IDX_W-1:0] last;  // Last occupied cell, for a rotate.
   } cell_cmd_type;

   // One result item.
   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   entry_value;
      logic [COUNT_W-1:0]   entry_count;
      logic                 final_item;
   } rsp_item_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } ple_state_type;

endpackage

>>> hw/rtl/ple_cell.sv
// One storage cell of the shifting list chain.
`timescale 1ns / 1ps
module ple_cell
   import ple_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] ins_value,
   input  logic [DATA_WIDTH-1:0] left_value,
   input  logic [DATA_WIDTH-1:0] right_value,
   input  logic [DATA_WIDTH-1:0] head_value,
   output logic [DATA_WIDTH-1:0] value_ff
);

   localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

   logic [DATA_WIDTH-1:0] value_in;

   // Pick the neighbor, the new value or the head according to the command.
   always_comb begin
      value_in = value_ff;
      unique case (cmd.kind)
         CELL_INSERT: begin
            if (MY_IDX > cmd.idx) begin
               value_in = left_value;
            end else if (MY_IDX == cmd.idx) begin
               value_in = ins_value;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= cmd.idx) begin
               value_in = right_value;
            end
         end
         CELL_ROTATE: begin
            if (MY_IDX == cmd.last) begin
               value_in = head_value;
            end else begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Payload register, no reset.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> hw/rtl/ple_rsp_queue.sv
// Two-entry result queue that decouples the list from the result channel.
`timescale 1ns / 1ps
module ple_rsp_queue
   import ple_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         push_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic [1:0]   count_ff, count_in;
   rsp_item_type slot0_ff, slot0_in;
   rsp_item_type slot1_ff, slot1_in;
   logic         pop;

   assign push_ready = (count_ff != 2'd2);
   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_item   = slot0_ff;
   assign pop        = rsp_valid && rsp_ready;

   // Queue bookkeeping; a push only comes while there is room.
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            slot0_in = push_item;
         end else begin
            slot1_in = push_item;
         end
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

>>> hw/rtl/positional_list_engine_top.sv
// Top level of the positional list engine: control, cell chain and result queue.
//
// The block keeps an ordered list of up to CAPACITY values in a chain of cells.
// Input items arrive on the req_ stream: opcode, value and 1-based position.
// Insert and delete shift the cells at and behind the target place and give one
// result item with a status and the new entry count. A read-out rotates the chain
// by one cell per cycle while the queue has room and gives one result item per
// entry, in order, with rsp_tlast on the last; an empty list gives one result with
// the empty status. Opcode 7 is dropped without a result. rsp_tvalid rises in the
// cycle after acceptance for an insert, a delete or an empty read-out; the first
// result of a read-out is pushed from the read state that follows acceptance. An
// insert or delete leaves the block idle, so the next item can follow while the
// queue has room; a read-out holds req_tready low through one rotation step per
// entry and while the queue is full. Results go through a two-entry queue, so an
// item is still accepted while one finished result waits; when the receiver stalls
// and the queue is full, req_tready drops. Reset empties the list and the queue at
// once; no clearing pass runs, as cells beyond the entry count are never read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module positional_list_engine_top
   import ple_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode[2:0], value[34:3], position[40:35], zero fill
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // entry_value[31:0], entry_count[37:32], zero fill
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast    // final_item
);

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

   // Input field decode.
   logic [OPCODE_W-1:0]   req_opcode;
   logic [VALUE_W-1:0]    req_value;
   logic [POSITION_W-1:0] req_position;
   logic                  req_acc;

   assign req_opcode   = req_tdata[2:0];
   assign req_value    = req_tdata[34:3];
   assign req_position = req_tdata[40:35];
   assign req_acc      = req_tvalid && req_tready;

   // Control state.
   ple_state_type state_ff, state_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [OCC_W-1:0] rd_cnt_ff, rd_cnt_in;

   // Comparison helpers, wide enough for occupancy plus one.
   logic [7:0] pos8, occ8, occ_last8;
   assign pos8      = 8'(req_position);
   assign occ8      = 8'(occ_ff);
   assign occ_last8 = occ8 - 8'd1;

   // Chain signals.
   cell_cmd_type          cmd;
   logic [DATA_WIDTH-1:0] ins_value;
   logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
   logic [VALUE_W-1:0]    head_ext;

   // Queue signals.
   logic         q_push, q_ready;
   rsp_item_type q_item, out_item;
   status_type   stat;
   logic         rd_final;

   // Value width adaption in both directions.
   always_comb begin
      ins_value = '0;
      ins_value[EXT_W-1:0] = req_value[EXT_W-1:0];
      head_ext = '0;
      head_ext[EXT_W-1:0] = cell_q[0][EXT_W-1:0];
   end

   assign rd_final = (8'(rd_cnt_ff) == occ_last8);

   // Input is taken only while idle and the queue has room.
   assign req_tready = (state_ff == ST_IDLE) && q_ready;

   // Next state, chain command and result generation.
   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      rd_cnt_in  = rd_cnt_ff;
      cmd        = '{kind: CELL_HOLD, idx: '0, last: CELL_IDX_W'(occ_last8)};
      stat       = STAT_OK;
      q_push     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               q_push = 1'b1;
               unique case (op_type'(req_opcode))
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                     if (op_type'(req_opcode) == OP_INS_POS &&
                         (pos8 == 8'd0 || pos8 > occ8 + 8'd1)) begin
                        stat = STAT_BAD_POS;
                     end else if (occ8 == 8'(CAPACITY)) begin
                        stat = STAT_FULL;
                     end else begin
                        cmd.kind = CELL_INSERT;
                        priority if (op_type'(req_opcode) == OP_INS_FRONT) begin
                           cmd.idx = '0;
                        end else if (op_type'(req_opcode) == OP_INS_BACK) begin
                           cmd.idx = CELL_IDX_W'(occ8);
                        end else begin
                           cmd.idx = CELL_IDX_W'(pos8 - 8'd1);
                        end
                        occ_in = occ_ff + OCC_W'(1);
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                     if (occ8 == 8'd0) begin
                        stat = STAT_EMPTY;
                     end else if (op_type'(req_opcode) == OP_DEL_POS &&
                                  (pos8 == 8'd0 || pos8 > occ8)) begin
                        stat = STAT_BAD_POS;
                     end else begin
                        cmd.kind = CELL_DELETE;
                        priority if (op_type'(req_opcode) == OP_DEL_FRONT) begin
                           cmd.idx = '0;
                        end else if (op_type'(req_opcode) == OP_DEL_BACK) begin
                           cmd.idx = CELL_IDX_W'(occ_last8);
                        end else begin
                           cmd.idx = CELL_IDX_W'(pos8 - 8'd1);
                        end
                        occ_in = occ_ff - OCC_W'(1);
                     end
                  end
                  OP_READ_ALL: begin
                     if (occ8 == 8'd0) begin
                        stat = STAT_EMPTY;
                     end else begin
                        // The read-out itself starts in the next cycle.
                        q_push    = 1'b0;
                        state_in  = ST_READ;
                        rd_cnt_in = '0;
                     end
                  end
                  default: begin
                     q_push = 1'b0;
                  end
               endcase
            end
         end
         ST_READ: begin
            // Emit the head cell and rotate the occupied part of the chain.
            if (q_ready) begin
               q_push   = 1'b1;
               cmd.kind = CELL_ROTATE;
               if (rd_final) begin
                  state_in  = ST_IDLE;
                  rd_cnt_in = '0;
               end else begin
                  rd_cnt_in = rd_cnt_ff + OCC_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result item for the queue.
   always_comb begin
      if (state_ff == ST_READ) begin
         q_item = '{status: STAT_OK, entry_value: head_ext,
                    entry_count: COUNT_W'(occ_ff), final_item: rd_final};
      end else begin
         q_item = '{status: stat, entry_value: '0,
                    entry_count: COUNT_W'(occ_in), final_item: 1'b1};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         occ_ff    <= '0;
         rd_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         rd_cnt_ff <= rd_cnt_in;
      end
   end

   // Chain of cells; each takes from its left or right neighbor, the new value or the head.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_v;
      logic [DATA_WIDTH-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = ins_value;
      end else begin : g_inner_l
         assign left_v = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_q[i];
      end else begin : g_inner_r
         assign right_v = cell_q[i+1];
      end
      ple_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .ins_value   (ins_value),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_q[0]),
         .value_ff    (cell_q[i])
      );
   end

   // Result queue.
   ple_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .push_ready (q_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.entry_count, out_item.entry_value};
   assign rsp_tuser = out_item.status;
   assign rsp_tlast = out_item.final_item;

   // The entry count never passes the capacity.
   `PLE_ASSERT(a_occ_bound, clock, reset, (occ_ff <= OCC_W'(CAPACITY)), "occupancy over capacity")
   // No item is taken during a read-out.
   `PLE_ASSERT(a_read_blocks, clock, reset, (state_ff == ST_READ |-> !req_tready), "accept in read-out")
   // A read-out of a non-empty list enters the read state.
   `PLE_ASSERT(a_read_start, clock, reset, (req_acc && req_opcode == OP_READ_ALL && occ_ff != '0 |=> state_ff == ST_READ), "read-out did not start")
   // The list does not change size while it is read out.
   `PLE_ASSERT(a_read_stable, clock, reset, (state_ff == ST_READ |=> occ_ff == $past(occ_ff)), "count changed in read-out")

endmodule
